// File: rtl/tmt_pkg.sv
// Tempo map table: shared types and constants.
// Entry layout, action and status codes, fixed-point widths.
// No dependencies.
package tmt_pkg;

  localparam int POS_W   = 48;
  localparam int TEMPO_W = 26;
  localparam int SIG_W   = 7;
  localparam int RATE_W  = 19;
  localparam int D_W     = 25;
  localparam int BC_W    = 40;
  localparam int BAR_W   = 20;
  localparam int RES_W   = 63;
  localparam int ACC_W   = 84;
  localparam int DIV_NW  = 80;
  localparam int DIV_DW  = 48;

  localparam logic [2:0] ACT_SET_TEMPO  = 3'd0;
  localparam logic [2:0] ACT_SET_SIG    = 3'd1;
  localparam logic [2:0] ACT_REMOVE     = 3'd2;
  localparam logic [2:0] ACT_QUERY      = 3'd3;
  localparam logic [2:0] ACT_TO_BEATS   = 3'd4;
  localparam logic [2:0] ACT_TO_SAMPLES = 3'd5;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX = 3'd3;
  localparam logic [2:0] ST_SAT       = 3'd4;

  localparam logic [TEMPO_W-1:0] TEMPO_120    = 26'h078_0000;
  localparam logic [SIG_W-1:0]   SIG_DEFAULT  = 7'd4;
  localparam logic [RATE_W-1:0]  RATE_DEFAULT = 19'd48000;
  localparam logic [D_W-1:0]     SEC_PER_MIN  = 25'd60;
  localparam logic [RES_W-1:0]   RES_MAX      = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [TEMPO_W-1:0] tempo;
    logic [SIG_W-1:0]   num;
    logic [SIG_W-1:0]   den;
  } ent_t;

  localparam ent_t ENT_RESET = '{pos: '0, tempo: TEMPO_120,
                                 num: SIG_DEFAULT, den: SIG_DEFAULT};

endpackage

// File: rtl/tmt_ram.sv
// Tempo map table: generic simple dual-port RAM.
// One write port, one read port, read data registered.
// No dependencies.
module tmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/tmt_div.sv
// Tempo map table: restoring divider, one quotient bit per cycle.
// Depends on tmt_pkg for operand widths.
module tmt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tmt_pkg::DIV_NW-1:0] dividend,
  input  logic [tmt_pkg::DIV_DW-1:0] divisor,
  output logic                       done,
  output logic [tmt_pkg::DIV_NW-1:0] quotient
);

  localparam int NW    = tmt_pkg::DIV_NW;
  localparam int DW    = tmt_pkg::DIV_DW;
  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NW-1:0]    quo_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    den_r;

  logic [DW:0]      r2;
  logic [DW:0]      diff;
  logic             ge;
  logic [NW-1:0]    quo_nxt;
  logic [DW-1:0]    rem_nxt;

  always_comb begin
    r2      = {rem_r, quo_r[NW-1]};
    diff    = r2 - {1'b0, den_r};
    ge      = (r2 >= {1'b0, den_r});
    rem_nxt = ge ? diff[DW-1:0] : r2[DW-1:0];
    quo_nxt = {quo_r[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        den_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(NW);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/tempo_map_table.sv
// Tempo map table: top level, sequencer around the entry RAM.
// Depends on tmt_pkg, tmt_ram and tmt_div.
//
// Usage:
//   Input transactions (in_valid/in_ready) carry one action; each gives one
//   output transaction (out_valid/out_ready) with the entry in effect at
//   in_position, the conversion result, the entry count and a status.
//   One transaction is processed at a time; in_ready is high while idle.
//   Every action ends with a locate scan of the entries.
//   Edits add the search and, on an insert or a remove, the shift.
//   Samples-to-beats walks the entries, with a multiply per entry walked,
//   then a multiply and a divide. Beats-to-samples: a multiply and a
//   divide. Bar walk: up to two divides per entry walked, on the
//   shared bit-serial divider and the 16-bit-slice multiplier.
//   sample_rate is written through cfg_wr_en/cfg_wr_data only while idle;
//   the user must ensure this, the block does not. Reset: the count goes
//   to one and an init pass writes entry 0 (120 bpm, 4/4 at sample 0)
//   before the first input is taken. A finished result waits in the output
//   register during a stall; the next input is taken and waits at its end.
module tempo_map_table #(
  parameter int MAX_EVENTS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_action,
  input  logic [47:0]                  in_position,
  input  logic [25:0]                  in_tempo_q16,
  input  logic [6:0]                   in_beats_per_bar,
  input  logic [6:0]                   in_beat_unit,
  input  logic [7:0]                   in_entry_index,
  input  logic [39:0]                  in_beat_count_q16,
  input  logic [19:0]                  in_bar_number,
  input  logic                         in_bar_mode,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [25:0]                  out_tempo_out_q16,
  output logic [6:0]                   out_numerator_out,
  output logic [6:0]                   out_denominator_out,
  output logic [62:0]                  out_beats_out_q16,
  output logic [62:0]                  out_samples_out,
  output logic [4:0]                   out_entries_in_use,
  output logic [2:0]                   out_status,
  input  logic                         cfg_wr_en,
  input  logic [18:0]                  cfg_wr_data
);

  localparam int IW    = $clog2(MAX_EVENTS);
  localparam int CW    = $clog2(MAX_EVENTS + 1);
  localparam int ENT_W = $bits(tmt_pkg::ent_t);
  localparam int ACW   = tmt_pkg::ACC_W;
  localparam int RW    = tmt_pkg::RES_W;
  localparam int NW    = tmt_pkg::DIV_NW;
  localparam int DW    = tmt_pkg::DIV_DW;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_LRD, S_LCHK, S_EDIT, S_SHRD, S_SHWR, S_WRD, S_WCHK,
    S_MUL, S_DIVW, S_RD0, S_TCHK, S_BRD, S_BCHK, S_BLEN, S_BDEC, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    PH_SEG, PH_QUO, PH_BLEN, PH_BK, PH_BMUL
  } phase_t;

  state_t                  state_r, state_nxt;
  phase_t                  phase_r, phase_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [18:0]             rate_r, rate_nxt;
  logic [2:0]              act_r, act_nxt;
  logic [47:0]             pin_r, pin_nxt;
  logic [25:0]             tin_r, tin_nxt;
  logic [6:0]              nb_r, nb_nxt;
  logic [6:0]              nu_r, nu_nxt;
  logic [39:0]             bc_r, bc_nxt;
  logic                    bm_r, bm_nxt;
  logic [19:0]             rem_r, rem_nxt;
  logic [CW-1:0]           i_r, i_nxt;
  logic [CW-1:0]           j_r, j_nxt;
  logic [CW-1:0]           k_r, k_nxt;
  logic                    up_r, up_nxt;
  logic                    loc_edit_r, loc_edit_nxt;
  logic                    btail_r, btail_nxt;
  tmt_pkg::ent_t           kent_r, kent_nxt;
  tmt_pkg::ent_t           rent_r, rent_nxt;
  logic [2:0]              status_r, status_nxt;
  logic [RW-1:0]           beats_r, beats_nxt;
  logic [RW-1:0]           samples_r, samples_nxt;
  logic [ACW-1:0]          acc_r, acc_nxt;
  logic [63:0]             ma_r, ma_nxt;
  logic [25:0]             mb_r, mb_nxt;
  logic [1:0]              mstep_r, mstep_nxt;
  logic [RW-1:0]           pos_r, pos_nxt;
  logic [25:0]             cur_r, cur_nxt;
  logic [6:0]              num_r, num_nxt;
  logic [RW-1:0]           s_r, s_nxt;
  logic                    div_start_r, div_start_nxt;
  logic [NW-1:0]           div_num_r, div_num_nxt;
  logic [DW-1:0]           div_den_r, div_den_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [25:0]             o_tempo_r, o_tempo_nxt;
  logic [6:0]              o_num_r, o_num_nxt;
  logic [6:0]              o_den_r, o_den_nxt;
  logic [RW-1:0]           o_beats_r, o_beats_nxt;
  logic [RW-1:0]           o_samples_r, o_samples_nxt;
  logic [4:0]              o_cnt_r, o_cnt_nxt;
  logic [2:0]              o_status_r, o_status_nxt;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr;
  logic [ENT_W-1:0]        ram_wdata;
  logic [IW-1:0]           ram_raddr;
  logic [ENT_W-1:0]        ram_rdata;
  tmt_pkg::ent_t           rd;

  logic                    div_done;
  logic [NW-1:0]           div_quo;

  logic [18:0]             rate_eff;
  logic [tmt_pkg::D_W-1:0] d_val;
  logic [41:0]             mprod;
  logic [31:0]             blen_prod;

  tmt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_EVENTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tmt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_num_r),
    .divisor  (div_den_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign rd        = tmt_pkg::ent_t'(ram_rdata);
  assign rate_eff  = (rate_r == '0) ? 19'd1 : rate_r;
  assign d_val     = tmt_pkg::D_W'(rate_eff) * tmt_pkg::SEC_PER_MIN;
  assign mprod     = 42'(ma_r[{mstep_r, 4'b0000} +: 16]) * 42'(mb_r);
  assign blen_prod = 32'(num_r) * 32'(d_val);

  always_comb begin
    logic [ACW-1:0] acc_sum;
    logic           sat;
    logic [RW-1:0]  res;
    logic [CW-1:0]  sh_src;

    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    rate_nxt      = cfg_wr_en ? cfg_wr_data : rate_r;
    act_nxt       = act_r;
    pin_nxt       = pin_r;
    tin_nxt       = tin_r;
    nb_nxt        = nb_r;
    nu_nxt        = nu_r;
    bc_nxt        = bc_r;
    bm_nxt        = bm_r;
    rem_nxt       = rem_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    up_nxt        = up_r;
    loc_edit_nxt  = loc_edit_r;
    btail_nxt     = btail_r;
    kent_nxt      = kent_r;
    rent_nxt      = rent_r;
    status_nxt    = status_r;
    beats_nxt     = beats_r;
    samples_nxt   = samples_r;
    acc_nxt       = acc_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    mstep_nxt     = mstep_r;
    pos_nxt       = pos_r;
    cur_nxt       = cur_r;
    num_nxt       = num_r;
    s_nxt         = s_r;
    div_start_nxt = 1'b0;
    div_num_nxt   = div_num_r;
    div_den_nxt   = div_den_r;
    out_valid_nxt = out_valid_r;
    o_tempo_nxt   = o_tempo_r;
    o_num_nxt     = o_num_r;
    o_den_nxt     = o_den_r;
    o_beats_nxt   = o_beats_r;
    o_samples_nxt = o_samples_r;
    o_cnt_nxt     = o_cnt_r;
    o_status_nxt  = o_status_r;

    ram_we    = 1'b0;
    ram_waddr = k_r[IW-1:0];
    ram_wdata = kent_r;
    ram_raddr = i_r[IW-1:0];

    acc_sum = acc_r + (ACW'(mprod) << {mstep_r, 4'b0000});
    sat     = 1'b0;
    res     = '0;
    sh_src  = up_r ? (j_r - CW'(1)) : (j_r + CW'(1));

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = tmt_pkg::ENT_RESET;
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid) begin
          act_nxt      = in_action;
          pin_nxt      = in_position;
          tin_nxt      = in_tempo_q16;
          nb_nxt       = in_beats_per_bar;
          nu_nxt       = in_beat_unit;
          bc_nxt       = in_beat_count_q16;
          bm_nxt       = in_bar_mode;
          rem_nxt      = in_bar_number;
          status_nxt   = tmt_pkg::ST_OK;
          beats_nxt    = '0;
          samples_nxt  = '0;
          acc_nxt      = '0;
          pos_nxt      = '0;
          i_nxt        = '0;
          loc_edit_nxt = 1'b0;
          state_nxt    = S_LRD;
          unique case (in_action)
            tmt_pkg::ACT_SET_TEMPO, tmt_pkg::ACT_SET_SIG: begin
              loc_edit_nxt = 1'b1;
            end
            tmt_pkg::ACT_REMOVE: begin
              if (in_entry_index == 8'd0 || 32'(in_entry_index) >= 32'(cnt_r)) begin
                status_nxt = tmt_pkg::ST_BAD_INDEX;
              end else begin
                j_nxt     = CW'(in_entry_index);
                up_nxt    = 1'b0;
                state_nxt = S_SHRD;
              end
            end
            tmt_pkg::ACT_TO_BEATS: begin
              state_nxt = S_WRD;
            end
            tmt_pkg::ACT_TO_SAMPLES: begin
              state_nxt = S_RD0;
            end
            default: begin
              state_nxt = S_LRD;
            end
          endcase
        end
      end

      S_LRD: begin
        if (i_r < cnt_r) begin
          state_nxt = S_LCHK;
        end else begin
          state_nxt = loc_edit_r ? S_EDIT : S_DONE;
        end
      end

      S_LCHK: begin
        if (rd.pos <= pin_r) begin
          kent_nxt  = rd;
          k_nxt     = i_r;
          i_nxt     = i_r + CW'(1);
          state_nxt = S_LRD;
        end else begin
          state_nxt = loc_edit_r ? S_EDIT : S_DONE;
        end
      end

      S_EDIT: begin
        i_nxt        = '0;
        loc_edit_nxt = 1'b0;
        state_nxt    = S_LRD;
        if (kent_r.pos == pin_r) begin
          ram_we = 1'b1;
          if (act_r == tmt_pkg::ACT_SET_TEMPO) begin
            ram_wdata = tmt_pkg::ent_t'{pos: kent_r.pos, tempo: tin_r,
                                        num: kent_r.num, den: kent_r.den};
          end else begin
            ram_wdata = tmt_pkg::ent_t'{pos: kent_r.pos, tempo: kent_r.tempo,
                                        num: nb_r, den: nu_r};
          end
          status_nxt = tmt_pkg::ST_UPDATED;
        end else if (cnt_r >= CW'(MAX_EVENTS)) begin
          status_nxt = tmt_pkg::ST_FULL;
        end else begin
          j_nxt     = cnt_r;
          up_nxt    = 1'b1;
          state_nxt = S_SHRD;
        end
      end

      S_SHRD: begin
        ram_raddr = sh_src[IW-1:0];
        if (up_r) begin
          if (j_r > k_r + CW'(1)) begin
            state_nxt = S_SHWR;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = IW'(k_r + CW'(1));
            if (act_r == tmt_pkg::ACT_SET_TEMPO) begin
              ram_wdata = tmt_pkg::ent_t'{pos: pin_r, tempo: tin_r,
                                          num: kent_r.num, den: kent_r.den};
            end else begin
              ram_wdata = tmt_pkg::ent_t'{pos: pin_r, tempo: kent_r.tempo,
                                          num: nb_r, den: nu_r};
            end
            cnt_nxt   = cnt_r + CW'(1);
            i_nxt     = '0;
            state_nxt = S_LRD;
          end
        end else begin
          if (j_r + CW'(1) < cnt_r) begin
            state_nxt = S_SHWR;
          end else begin
            cnt_nxt   = cnt_r - CW'(1);
            i_nxt     = '0;
            state_nxt = S_LRD;
          end
        end
      end

      S_SHWR: begin
        ram_we    = 1'b1;
        ram_waddr = j_r[IW-1:0];
        ram_wdata = rd;
        j_nxt     = up_r ? (j_r - CW'(1)) : (j_r + CW'(1));
        state_nxt = S_SHRD;
      end

      S_WRD: begin
        if (i_r == '0 || i_r < cnt_r) begin
          state_nxt = S_WCHK;
        end else begin
          ma_nxt      = 64'(pin_r - pos_r[47:0]);
          mb_nxt      = cur_r;
          mstep_nxt   = '0;
          phase_nxt   = PH_QUO;
          div_den_nxt = DW'(d_val);
          state_nxt   = S_MUL;
        end
      end

      S_WCHK: begin
        if (i_r == '0) begin
          cur_nxt   = rd.tempo;
          i_nxt     = CW'(1);
          state_nxt = S_WRD;
        end else if (rd.pos >= pin_r) begin
          ma_nxt      = 64'(pin_r - pos_r[47:0]);
          mb_nxt      = cur_r;
          mstep_nxt   = '0;
          phase_nxt   = PH_QUO;
          div_den_nxt = DW'(d_val);
          state_nxt   = S_MUL;
        end else begin
          ma_nxt    = 64'(rd.pos - pos_r[47:0]);
          mb_nxt    = cur_r;
          cur_nxt   = rd.tempo;
          pos_nxt   = RW'(rd.pos);
          i_nxt     = i_r + CW'(1);
          mstep_nxt = '0;
          phase_nxt = PH_SEG;
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        acc_nxt   = acc_sum;
        mstep_nxt = mstep_r + 2'd1;
        if (mstep_r == 2'd3) begin
          unique case (phase_r)
            PH_SEG: begin
              state_nxt = S_WRD;
            end
            PH_QUO: begin
              div_start_nxt = 1'b1;
              div_num_nxt   = acc_sum[NW-1:0];
              state_nxt     = S_DIVW;
            end
            default: begin
              if (|acc_sum[ACW-1:RW]) begin
                samples_nxt = tmt_pkg::RES_MAX;
                status_nxt  = tmt_pkg::ST_SAT;
              end else begin
                samples_nxt = acc_sum[RW-1:0];
              end
              i_nxt     = '0;
              state_nxt = S_LRD;
            end
          endcase
        end
      end

      S_DIVW: begin
        if (div_done) begin
          unique case (phase_r)
            PH_BLEN: begin
              s_nxt     = div_quo[RW-1:0];
              state_nxt = S_BDEC;
            end
            PH_BK: begin
              if (div_quo >= NW'(rem_r)) begin
                acc_nxt   = ACW'(pos_r);
                ma_nxt    = 64'(s_r);
                mb_nxt    = 26'(rem_r);
                rem_nxt   = '0;
                mstep_nxt = '0;
                phase_nxt = PH_BMUL;
                state_nxt = S_MUL;
              end else begin
                rem_nxt   = rem_r - div_quo[19:0];
                pos_nxt   = RW'(rent_r.pos);
                cur_nxt   = rent_r.tempo;
                num_nxt   = rent_r.num;
                i_nxt     = i_r + CW'(1);
                state_nxt = S_BRD;
              end
            end
            default: begin
              sat = |div_quo[NW-1:RW];
              res = sat ? tmt_pkg::RES_MAX : div_quo[RW-1:0];
              if (act_r == tmt_pkg::ACT_TO_BEATS) begin
                beats_nxt = res;
              end else begin
                samples_nxt = res;
              end
              if (sat) begin
                status_nxt = tmt_pkg::ST_SAT;
              end
              i_nxt     = '0;
              state_nxt = S_LRD;
            end
          endcase
        end
      end

      S_RD0: begin
        state_nxt = S_TCHK;
      end

      S_TCHK: begin
        cur_nxt = rd.tempo;
        num_nxt = rd.num;
        if (!bm_r) begin
          if (rd.tempo == '0) begin
            if (bc_r != '0) begin
              samples_nxt = tmt_pkg::RES_MAX;
              status_nxt  = tmt_pkg::ST_SAT;
            end
            i_nxt     = '0;
            state_nxt = S_LRD;
          end else begin
            ma_nxt      = 64'(bc_r);
            mb_nxt      = 26'(d_val);
            div_den_nxt = DW'(rd.tempo);
            mstep_nxt   = '0;
            phase_nxt   = PH_QUO;
            state_nxt   = S_MUL;
          end
        end else begin
          i_nxt     = CW'(1);
          state_nxt = S_BRD;
        end
      end

      S_BRD: begin
        if (i_r < cnt_r && rem_r != '0) begin
          state_nxt = S_BCHK;
        end else if (rem_r == '0) begin
          samples_nxt = pos_r;
          i_nxt       = '0;
          state_nxt   = S_LRD;
        end else begin
          btail_nxt = 1'b1;
          state_nxt = S_BLEN;
        end
      end

      S_BCHK: begin
        rent_nxt  = rd;
        btail_nxt = 1'b0;
        state_nxt = S_BLEN;
      end

      S_BLEN: begin
        if (cur_r == '0) begin
          s_nxt     = tmt_pkg::RES_MAX;
          state_nxt = S_BDEC;
        end else begin
          div_start_nxt = 1'b1;
          div_num_nxt   = NW'({blen_prod, 16'h0000});
          div_den_nxt   = DW'(cur_r);
          phase_nxt     = PH_BLEN;
          state_nxt     = S_DIVW;
        end
      end

      S_BDEC: begin
        if (btail_r) begin
          if (s_r == '0) begin
            samples_nxt = pos_r;
            i_nxt       = '0;
            state_nxt   = S_LRD;
          end else begin
            acc_nxt   = ACW'(pos_r);
            ma_nxt    = 64'(s_r);
            mb_nxt    = 26'(rem_r);
            mstep_nxt = '0;
            phase_nxt = PH_BMUL;
            state_nxt = S_MUL;
          end
        end else if (s_r == '0) begin
          rem_nxt   = '0;
          state_nxt = S_BRD;
        end else if (cur_r == '0) begin
          pos_nxt   = RW'(rent_r.pos);
          cur_nxt   = rent_r.tempo;
          num_nxt   = rent_r.num;
          i_nxt     = i_r + CW'(1);
          state_nxt = S_BRD;
        end else begin
          div_start_nxt = 1'b1;
          div_num_nxt   = NW'(rent_r.pos - pos_r[47:0]);
          div_den_nxt   = s_r[DW-1:0];
          phase_nxt     = PH_BK;
          state_nxt     = S_DIVW;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_tempo_nxt   = kent_r.tempo;
          o_num_nxt     = kent_r.num;
          o_den_nxt     = kent_r.den;
          o_beats_nxt   = beats_r;
          o_samples_nxt = samples_r;
          o_cnt_nxt     = 5'(cnt_r);
          o_status_nxt  = status_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= CW'(1);
      rate_r      <= tmt_pkg::RATE_DEFAULT;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rate_r      <= rate_nxt;
      out_valid_r <= out_valid_nxt;
      div_start_r <= div_start_nxt;
      phase_r     <= phase_nxt;
      act_r       <= act_nxt;
      pin_r       <= pin_nxt;
      tin_r       <= tin_nxt;
      nb_r        <= nb_nxt;
      nu_r        <= nu_nxt;
      bc_r        <= bc_nxt;
      bm_r        <= bm_nxt;
      rem_r       <= rem_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      up_r        <= up_nxt;
      loc_edit_r  <= loc_edit_nxt;
      btail_r     <= btail_nxt;
      kent_r      <= kent_nxt;
      rent_r      <= rent_nxt;
      status_r    <= status_nxt;
      beats_r     <= beats_nxt;
      samples_r   <= samples_nxt;
      acc_r       <= acc_nxt;
      ma_r        <= ma_nxt;
      mb_r        <= mb_nxt;
      mstep_r     <= mstep_nxt;
      pos_r       <= pos_nxt;
      cur_r       <= cur_nxt;
      num_r       <= num_nxt;
      s_r         <= s_nxt;
      div_num_r   <= div_num_nxt;
      div_den_r   <= div_den_nxt;
      o_tempo_r   <= o_tempo_nxt;
      o_num_r     <= o_num_nxt;
      o_den_r     <= o_den_nxt;
      o_beats_r   <= o_beats_nxt;
      o_samples_r <= o_samples_nxt;
      o_cnt_r     <= o_cnt_nxt;
      o_status_r  <= o_status_nxt;
    end
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_tempo_out_q16   = o_tempo_r;
  assign out_numerator_out   = o_num_r;
  assign out_denominator_out = o_den_r;
  assign out_beats_out_q16   = o_beats_r;
  assign out_samples_out     = o_samples_r;
  assign out_entries_in_use  = o_cnt_r;
  assign out_status          = o_status_r;

endmodule

// File: dv/tb_tempo_map_table.sv
// Self-checking testbench for tempo_map_table: random and directed edits,
// queries and conversions, checked against an in-bench model of the table.
// Depends on rtl/tmt_pkg.sv and rtl/tempo_map_table.sv.
`timescale 1ns / 1ps

module tb_tempo_map_table;

  localparam int          DEPTH      = 16;
  localparam logic [2:0]  ACT_SPARE  = tmt_pkg::ACT_TO_SAMPLES + 3'd1;
  localparam logic [63:0] SAT_VAL    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint      CYCLE_CAP  = 64'd20_000_000;
  localparam logic [18:0] RATE_MAX19 = 19'h7FFFF;
  localparam int          LONG_HOLD  = 600;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] pos;
    logic [25:0] tempo;
    logic [6:0]  bpb;
    logic [6:0]  unit;
    logic [7:0]  index;
    logic [39:0] beat_cnt;
    logic [19:0] bars;
    logic        bar_mode;
  } txn_t;

  typedef struct packed {
    logic [25:0] tempo;
    logic [6:0]  num;
    logic [6:0]  den;
    logic [62:0] beats;
    logic [62:0] samples;
    logic [4:0]  count;
    logic [2:0]  status;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0]  in_action = '0;
  logic [47:0] in_position = '0;
  logic [25:0] in_tempo_q16 = '0;
  logic [6:0]  in_beats_per_bar = '0;
  logic [6:0]  in_beat_unit = '0;
  logic [7:0]  in_entry_index = '0;
  logic [39:0] in_beat_count_q16 = '0;
  logic [19:0] in_bar_number = '0;
  logic        in_bar_mode = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [25:0] out_tempo_out_q16;
  logic [6:0]  out_numerator_out;
  logic [6:0]  out_denominator_out;
  logic [62:0] out_beats_out_q16;
  logic [62:0] out_samples_out;
  logic [4:0]  out_entries_in_use;
  logic [2:0]  out_status;
  logic        cfg_wr_en = 1'b0;
  logic [18:0] cfg_wr_data = '0;

  tempo_map_table #(.MAX_EVENTS(DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_action(in_action), .in_position(in_position),
    .in_tempo_q16(in_tempo_q16), .in_beats_per_bar(in_beats_per_bar),
    .in_beat_unit(in_beat_unit), .in_entry_index(in_entry_index),
    .in_beat_count_q16(in_beat_count_q16), .in_bar_number(in_bar_number),
    .in_bar_mode(in_bar_mode),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_tempo_out_q16(out_tempo_out_q16), .out_numerator_out(out_numerator_out),
    .out_denominator_out(out_denominator_out), .out_beats_out_q16(out_beats_out_q16),
    .out_samples_out(out_samples_out), .out_entries_in_use(out_entries_in_use),
    .out_status(out_status),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // table model
  logic [47:0] ev_pos[DEPTH];
  logic [25:0] ev_tempo[DEPTH];
  logic [6:0]  ev_num[DEPTH];
  logic [6:0]  ev_den[DEPTH];
  int          ev_count = 1;
  logic [18:0] rate_reg = tmt_pkg::RATE_DEFAULT;

  result_t expected_q[$];
  int      mismatches = 0;
  int      checked = 0;
  int      n_sent = 0;
  int      n_full = 0;
  int      n_sat = 0;
  bit      quiet = 1'b0;
  bit      hold_req = 1'b0;
  bit      hold_taken = 1'b0;
  int      rx_hold = 0;
  longint  cycles = 0;

  initial begin
    ev_pos[0] = '0;
    ev_tempo[0] = tmt_pkg::TEMPO_120;
    ev_num[0] = tmt_pkg::SIG_DEFAULT;
    ev_den[0] = tmt_pkg::SIG_DEFAULT;
  end

  function automatic int locate(logic [47:0] p);
    int idx;
    idx = 0;
    for (int i = 0; i < ev_count; i++) begin
      if (ev_pos[i] > p) break;
      idx = i;
    end
    return idx;
  endfunction

  function automatic logic [63:0] bar_len(logic [63:0] nm, logic [63:0] tp, logic [63:0] d);
    if (tp == 0) return SAT_VAL;
    return (nm * d * 64'd65536) / tp;
  endfunction

  function automatic result_t apply_action(txn_t t);
    result_t r;
    logic [63:0]  d, prev, cur, pos, rem, s, k, nm;
    logic [127:0] acc, q;
    int           idx, ins;
    bit           sat, found;
    r = '{default: '0};
    d = 64'd60 * ((rate_reg == 0) ? 64'd1 : 64'(rate_reg));
    sat = 1'b0;
    found = 1'b0;
    r.status = tmt_pkg::ST_OK;
    if (t.action == tmt_pkg::ACT_SET_TEMPO || t.action == tmt_pkg::ACT_SET_SIG) begin
      for (int i = 0; i < ev_count; i++) begin
        if (!found && ev_pos[i] == t.pos) begin
          if (t.action == tmt_pkg::ACT_SET_TEMPO) ev_tempo[i] = t.tempo;
          else begin
            ev_num[i] = t.bpb;
            ev_den[i] = t.unit;
          end
          r.status = tmt_pkg::ST_UPDATED;
          found = 1'b1;
        end
      end
      if (!found) begin
        if (ev_count >= DEPTH) r.status = tmt_pkg::ST_FULL;
        else begin
          idx = locate(t.pos);
          ins = idx + 1;
          for (int i = ev_count; i > ins; i--) begin
            ev_pos[i] = ev_pos[i-1];
            ev_tempo[i] = ev_tempo[i-1];
            ev_num[i] = ev_num[i-1];
            ev_den[i] = ev_den[i-1];
          end
          ev_pos[ins] = t.pos;
          ev_tempo[ins] = (t.action == tmt_pkg::ACT_SET_TEMPO) ? t.tempo : ev_tempo[idx];
          ev_num[ins] = (t.action == tmt_pkg::ACT_SET_TEMPO) ? ev_num[idx] : t.bpb;
          ev_den[ins] = (t.action == tmt_pkg::ACT_SET_TEMPO) ? ev_den[idx] : t.unit;
          ev_count++;
        end
      end
    end else if (t.action == tmt_pkg::ACT_REMOVE) begin
      if (t.index == 0 || t.index >= ev_count) r.status = tmt_pkg::ST_BAD_INDEX;
      else begin
        for (int i = t.index; i + 1 < ev_count; i++) begin
          ev_pos[i] = ev_pos[i+1];
          ev_tempo[i] = ev_tempo[i+1];
          ev_num[i] = ev_num[i+1];
          ev_den[i] = ev_den[i+1];
        end
        ev_count--;
      end
    end else if (t.action == tmt_pkg::ACT_TO_BEATS) begin
      acc = '0;
      prev = 0;
      cur = ev_tempo[0];
      for (int i = 1; i < ev_count; i++) begin
        if (ev_pos[i] >= t.pos) break;
        acc += 128'(ev_pos[i] - prev) * 128'(cur);
        prev = ev_pos[i];
        cur = ev_tempo[i];
      end
      acc += 128'(64'(t.pos) - prev) * 128'(cur);
      q = acc / d;
      if (q > SAT_VAL) begin
        sat = 1'b1;
        r.beats = SAT_VAL[62:0];
      end else r.beats = q[62:0];
    end else if (t.action == tmt_pkg::ACT_TO_SAMPLES) begin
      if (!t.bar_mode) begin
        if (ev_tempo[0] == 0) begin
          if (t.beat_cnt != 0) begin
            sat = 1'b1;
            r.samples = SAT_VAL[62:0];
          end
        end else begin
          q = (128'(t.beat_cnt) * 128'(d)) / 128'(ev_tempo[0]);
          if (q > SAT_VAL) begin
            sat = 1'b1;
            r.samples = SAT_VAL[62:0];
          end else r.samples = q[62:0];
        end
      end else begin
        pos = 0;
        rem = t.bars;
        cur = ev_tempo[0];
        nm = ev_num[0];
        for (int i = 1; i < ev_count && rem > 0; i++) begin
          s = bar_len(nm, cur, d);
          if (s == 0) k = rem;
          else begin
            k = (64'(ev_pos[i]) - pos) / s;
            if (k > rem) k = rem;
          end
          pos += k * s;
          rem -= k;
          if (rem == 0) break;
          cur = ev_tempo[i];
          nm = ev_num[i];
          pos = ev_pos[i];
        end
        if (rem > 0) begin
          s = bar_len(nm, cur, d);
          if (s != 0 && rem > (SAT_VAL - pos) / s) begin
            pos = SAT_VAL;
            sat = 1'b1;
          end else pos += rem * s;
        end
        r.samples = pos[62:0];
      end
    end
    if (sat) r.status = tmt_pkg::ST_SAT;
    idx = locate(t.pos);
    r.tempo = ev_tempo[idx];
    r.num = ev_num[idx];
    r.den = ev_den[idx];
    r.count = 5'(ev_count);
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t e, a;
    if (rst_n && out_valid && out_ready) begin
      a = '{out_tempo_out_q16, out_numerator_out, out_denominator_out,
            out_beats_out_q16, out_samples_out, out_entries_in_use, out_status};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", a);
      end else begin
        e = expected_q.pop_front();
        checked++;
        if (a.status == tmt_pkg::ST_FULL) n_full++;
        if (a.status == tmt_pkg::ST_SAT) n_sat++;
        if (a != e) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch #%0d\n  exp %p\n  got %p", checked, e, a);
        end
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      out_ready <= 1'b0;
      rx_hold <= LONG_HOLD - 1;
    end else if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      rx_hold <= $urandom_range(0, 7);
    end else out_ready <= 1'b1;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(txn_t t);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_action = t.action;
    in_position = t.pos;
    in_tempo_q16 = t.tempo;
    in_beats_per_bar = t.bpb;
    in_beat_unit = t.unit;
    in_entry_index = t.index;
    in_beat_count_q16 = t.beat_cnt;
    in_bar_number = t.bars;
    in_bar_mode = t.bar_mode;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(apply_action(t));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    wait (expected_q.size() == 0);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_rate(logic [18:0] v);
    wait_drained();
    cfg_wr_en = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    rate_reg = v;
  endtask

  function automatic txn_t make_item(logic [2:0] act, logic [47:0] p);
    txn_t t;
    t = '{act, p, tmt_pkg::TEMPO_120, 7'd3, 7'd8, 8'd1, 40'h1_0000, 20'd4, 1'b0};
    return t;
  endfunction

  logic [47:0] pos_pool[12] = '{48'd0, 48'd1, 48'd480, 48'd48000, 48'd96000, 48'd100000,
                                48'd250000, 48'd1000000, 48'd5000000, 48'hFFFF_FFFF,
                                48'h1234_5678_9ABC, 48'hFFFF_FFFF_FFFF};

  function automatic txn_t random_item();
    txn_t t;
    int   w;
    w = $urandom_range(0, 99);
    t.action = (w < 25) ? tmt_pkg::ACT_SET_TEMPO : (w < 40) ? tmt_pkg::ACT_SET_SIG :
               (w < 52) ? tmt_pkg::ACT_REMOVE : (w < 62) ? tmt_pkg::ACT_QUERY :
               (w < 78) ? tmt_pkg::ACT_TO_BEATS : (w < 97) ? tmt_pkg::ACT_TO_SAMPLES :
               3'($urandom_range(6, 7));
    case ($urandom_range(0, 3))
      0, 1: t.pos = pos_pool[$urandom_range(0, 11)];
      2: t.pos = 48'($urandom_range(0, 2_000_000));
      default: t.pos = 48'({$urandom, $urandom});
    endcase
    case ($urandom_range(0, 15))
      0: t.tempo = '0;
      1: t.tempo = 26'($urandom);
      default: t.tempo = 26'($urandom_range(32'd65536, 32'd67108863));
    endcase
    if ($urandom_range(0, 9) == 0) begin
      t.bpb = 7'($urandom);
      t.unit = 7'($urandom);
    end else begin
      t.bpb = 7'($urandom_range(1, 64));
      t.unit = 7'($urandom_range(1, 64));
    end
    t.index = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, ev_count));
    t.beat_cnt = 40'({$urandom, $urandom});
    t.bars = ($urandom_range(0, 2) == 0) ? 20'($urandom) : 20'($urandom_range(0, 64));
    t.bar_mode = 1'($urandom);
    return t;
  endfunction

  task automatic test_directed();
    txn_t t;
    send_item(make_item(tmt_pkg::ACT_QUERY, 48'd0));
    t = make_item(tmt_pkg::ACT_SET_TEMPO, 48'd1000);
    t.tempo = 26'd65536;
    send_item(t);
    t.tempo = 26'h3FF_FFFF;
    send_item(t);
    t = make_item(tmt_pkg::ACT_SET_SIG, 48'd500);
    t.bpb = 7'd64;
    t.unit = 7'd1;
    send_item(t);
    send_item(make_item(tmt_pkg::ACT_QUERY, 48'hFFFF_FFFF_FFFF));
    send_item(make_item(tmt_pkg::ACT_TO_BEATS, 48'd5000));
    send_item(make_item(tmt_pkg::ACT_TO_BEATS, 48'hFFFF_FFFF_FFFF));
    t = make_item(tmt_pkg::ACT_TO_SAMPLES, 48'd0);
    t.beat_cnt = 40'hFF_FFFF_FFFF;
    send_item(t);
    t.beat_cnt = '0;
    send_item(t);
    t.bar_mode = 1'b1;
    t.bars = 20'hFFFFF;
    send_item(t);
    t.bars = '0;
    send_item(t);
    t.bars = 20'd5;
    send_item(t);
    t = make_item(tmt_pkg::ACT_REMOVE, 48'd0);
    t.index = 8'd0;
    send_item(t);
    t.index = 8'd255;
    send_item(t);
    t.index = 8'd1;
    send_item(t);
    // zero tempo on the first entry
    t = make_item(tmt_pkg::ACT_SET_TEMPO, 48'd0);
    t.tempo = '0;
    send_item(t);
    t = make_item(tmt_pkg::ACT_TO_SAMPLES, 48'd10);
    t.beat_cnt = 40'd1;
    send_item(t);
    t.beat_cnt = '0;
    send_item(t);
    t.bar_mode = 1'b1;
    t.bars = 20'd3;
    send_item(t);
    send_item(make_item(tmt_pkg::ACT_TO_BEATS, 48'd12345));
    t = make_item(tmt_pkg::ACT_SET_TEMPO, 48'd0);
    send_item(t);
    send_item(make_item(ACT_SPARE, 48'd700));
    send_item(make_item(3'(ACT_SPARE + 3'd1), 48'd2000));
  endtask

  task automatic test_table_full();
    txn_t t;
    for (int i = 0; i < DEPTH + 1; i++) begin
      t = make_item(tmt_pkg::ACT_SET_SIG, 48'(i * 7919 + 3));
      t.bpb = 7'(i + 1);
      send_item(t);
    end
    t = make_item(tmt_pkg::ACT_TO_SAMPLES, 48'd0);
    t.bar_mode = 1'b1;
    t.bars = 20'd40;
    send_item(t);
    for (int i = 0; i < 6; i++) begin
      t = make_item(tmt_pkg::ACT_REMOVE, 48'd0);
      t.index = 8'($urandom_range(1, ev_count - 1));
      send_item(t);
    end
  endtask

  task automatic test_random(int n);
    repeat (n) send_item(random_item());
  endtask

  task automatic test_rate_sweep();
    logic [18:0] rates[5] = '{19'd8000, 19'd384000, 19'd0, RATE_MAX19, 19'd44100};
    foreach (rates[i]) begin
      write_rate(rates[i]);
      test_random(150);
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_req = 1'b1;
    test_random(30);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_table_full();
    test_rate_sweep();
    test_backpressure();
    write_rate(tmt_pkg::RATE_DEFAULT);
    quiet = 1'b1;
    test_random(250);
    in_valid = 1'b0;
    wait (expected_q.size() == 0);
    repeat (100) @(negedge clk);
    $display("sent %0d transactions, checked %0d results (%0d table full, %0d saturated)",
             n_sent, checked, n_full, n_sat);
    $display("covered edits, removes, queries, all conversions over five sample rates");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/tmt_pkg.sv
rtl/tmt_ram.sv
rtl/tmt_div.sv
rtl/tempo_map_table.sv
dv/tb_tempo_map_table.sv
